[rtl/min_tracking_stack_top_assert.svh]
// Assertion macros used by the checker file of the min tracking stack.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication that is also checked while reset is asserted.
`define MTS_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// Min tracking stack package
// Sizes, operation and status codes, and the types shared by the stack cells
// and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

   // Number of words the stack holds and the width of one word.
   localparam int DEPTH = 1024;
   localparam int WIDTH = 32;

   // Width of the fill counter, which must hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Widths of the fields on the ports.
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int VAL_W    = 32;
   localparam int COUNT_W  = 11;

   // Result beat layout: popped, top, min, count, empty, padded to bytes.
   localparam int RSP_BITS   = 3 * VAL_W + COUNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // One stack entry: the word and the minimum at or below its depth.
   typedef struct packed {
      logic [WIDTH-1:0] min_word;
      logic [WIDTH-1:0] word;
   } entry_type;

   // Shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

   // Sign-extend or cut a stored word to a 32-bit output field.
   function automatic logic [VAL_W-1:0] to_out32(input logic [WIDTH-1:0] w);
      logic signed [WIDTH-1:0] sw;
      sw = $signed(w);
      return VAL_W'(sw);
   endfunction

endpackage

`default_nettype wire

[rtl/mts_cell.sv]
// ----------------------------------------------------------------------------
// Min tracking stack cell
// One level of the shift stack: loads from the level above on a push and
// from the level below on a pop, and holds otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_cell (
   input  wire                        clock,
   input  wire mts_pkg::shift_type    shift,
   input  wire mts_pkg::entry_type    upper,
   input  wire mts_pkg::entry_type    lower,
   output mts_pkg::entry_type         entry
);

   mts_pkg::entry_type entry_ff;
   mts_pkg::entry_type entry_in;

   // Choose the neighbor to load from.
   always_comb begin
      priority if (shift.push) begin
         entry_in = upper;
      end else if (shift.pop) begin
         entry_in = lower;
      end else begin
         entry_in = entry_ff;
      end
   end

   // Payload only, so no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[rtl/min_tracking_stack_top.sv]
// This block is a last-in-first-out stack of DEPTH signed words that also
// reports the smallest word held. It takes one operation beat per cycle and
// answers each with one result beat in the next cycle; it keeps taking beats
// as long as its output register is empty or is being read in the same
// cycle. The rate is set by the chain of cells: a push or pop shifts every
// level by one place in the same cycle, so only the top two cells are ever
// read. No clearing pass runs after reset; the fill counter alone marks which
// levels are valid.
// ----------------------------------------------------------------------------
// Min tracking stack, top level
// Shift-register stack of cells with a fill counter and a registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack_top (
   input  wire                                  clock,
   input  wire                                  reset,
   // Operation channel.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [mts_pkg::VAL_W-1:0]            req_tdata,  // value
   input  wire  [mts_pkg::OP_W-1:0]             req_tuser,  // op
   // Result channel.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // popped_value, top_value, min_value, count, empty_res, zero padding
   output logic [mts_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [mts_pkg::STATUS_W-1:0]         rsp_tuser   // status
);

   localparam int D = mts_pkg::DEPTH;
   localparam int CW = mts_pkg::CNT_W;

   logic [CW-1:0]                   count_ff;
   logic [CW-1:0]                   count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [mts_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [mts_pkg::RSP_DATA_W-1:0]  rsp_data_in;
   logic [mts_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [mts_pkg::STATUS_W-1:0]    status;

   logic                            accept;
   logic                            is_empty;
   logic                            is_full;
   logic                            push_ok;
   logic                            pop_ok;
   logic [mts_pkg::WIDTH-1:0]       new_word;
   mts_pkg::entry_type              head;
   mts_pkg::shift_type              shift;
   mts_pkg::entry_type              cells [D];
   logic [mts_pkg::VAL_W-1:0]       popped;
   logic [mts_pkg::VAL_W-1:0]       top_val;
   logic [mts_pkg::VAL_W-1:0]       min_val;

   // Handshake: a new beat enters when the output register frees up.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(D));
   assign push_ok  = (req_tuser == mts_pkg::OP_PUSH) && !is_full;
   assign pop_ok   = (req_tuser == mts_pkg::OP_POP) && !is_empty;

   // The pushed word enters the top cell with its running minimum.
   assign new_word = mts_pkg::WIDTH'(req_tdata);
   always_comb begin
      head.word = new_word;
      if (is_empty || ($signed(new_word) < $signed(cells[0].min_word))) begin
         head.min_word = new_word;
      end else begin
         head.min_word = cells[0].min_word;
      end
   end

   assign shift.push = accept && push_ok;
   assign shift.pop  = accept && pop_ok;

   // Chain of cells, level zero on top.
   for (genvar i = 0; i < D; i++) begin : g_cell
      mts_pkg::entry_type up_entry;
      mts_pkg::entry_type down_entry;
      if (i == 0) begin : g_first
         assign up_entry = head;
      end else begin : g_mid_up
         assign up_entry = cells[i-1];
      end
      if (i == D - 1) begin : g_last
         assign down_entry = '0;
      end else begin : g_mid_down
         assign down_entry = cells[i+1];
      end
      mts_cell u_cell (
         .clock (clock),
         .shift (shift),
         .upper (up_entry),
         .lower (down_entry),
         .entry (cells[i])
      );
   end

   // Next fill count and the view of the stack after this step.
   always_comb begin
      count_in = count_ff;
      status   = mts_pkg::ST_OK;
      popped   = '0;
      top_val  = is_empty ? '0 : mts_pkg::to_out32(cells[0].word);
      min_val  = is_empty ? '0 : mts_pkg::to_out32(cells[0].min_word);
      unique case (req_tuser)
         mts_pkg::OP_PUSH: begin
            if (is_full) begin
               status = mts_pkg::ST_OVERFLOW;
            end else begin
               count_in = count_ff + CW'(1);
               top_val  = mts_pkg::to_out32(head.word);
               min_val  = mts_pkg::to_out32(head.min_word);
            end
         end
         mts_pkg::OP_POP: begin
            if (is_empty) begin
               status = mts_pkg::ST_UNDERFLOW;
            end else begin
               count_in = count_ff - CW'(1);
               popped   = mts_pkg::to_out32(cells[0].word);
               if (count_ff == CW'(1)) begin
                  top_val = '0;
                  min_val = '0;
               end else begin
                  top_val = mts_pkg::to_out32(cells[1].word);
                  min_val = mts_pkg::to_out32(cells[1].min_word);
               end
            end
         end
         mts_pkg::OP_CLEAR: begin
            count_in = '0;
            top_val  = '0;
            min_val  = '0;
         end
         mts_pkg::OP_QUERY: begin
            count_in = count_ff;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Pack the result beat.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[mts_pkg::RSP_BITS-1:0] = {(count_in == '0),
                                            mts_pkg::COUNT_W'(count_in),
                                            min_val, top_val, popped};
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/mts_checker.sv]
// ----------------------------------------------------------------------------
// Min tracking stack checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "min_tracking_stack_top_assert.svh"

module mts_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  rsp_tvalid,
   input wire                                  rsp_tready,
   input wire [mts_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input wire [mts_pkg::STATUS_W-1:0]          rsp_tuser
);

   logic                         rsp_stall;
   logic                         under_seen;
   logic                         over_seen;
   logic                         rsp_empty;
   logic                         rsp_full;
   logic [mts_pkg::COUNT_W-1:0]  rsp_count;
   logic [mts_pkg::VAL_W-1:0]    rsp_popped;

   // Fields of the result beat and the conditions the assertions key on.
   assign rsp_popped = rsp_tdata[mts_pkg::VAL_W-1:0];
   assign rsp_count  = rsp_tdata[3*mts_pkg::VAL_W +: mts_pkg::COUNT_W];
   assign rsp_empty  = rsp_tdata[mts_pkg::RSP_BITS-1];
   assign rsp_full   = (rsp_count == mts_pkg::COUNT_W'(mts_pkg::DEPTH));
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign under_seen = rsp_tvalid && (rsp_tuser == mts_pkg::ST_UNDERFLOW);
   assign over_seen  = rsp_tvalid && (rsp_tuser == mts_pkg::ST_OVERFLOW);

   // A stalled result beat holds its payload.
   `MTS_ASSERT_NEXT(a_hold, rsp_stall, $stable({rsp_tuser, rsp_tdata}), "stalled result changed")

   // The empty flag agrees with the reported count.
   `MTS_ASSERT_NOW(a_empty, rsp_tvalid, rsp_empty == (rsp_count == '0), "empty flag and count disagree")

   // An underflow leaves an empty stack with nothing popped.
   `MTS_ASSERT_NOW(a_under, under_seen, rsp_empty && (rsp_popped == '0), "underflow with words held")

   // An overflow is reported only with a full stack.
   `MTS_ASSERT_NOW(a_over, over_seen, rsp_full, "overflow on a stack that is not full")

   // No result beat comes out right after reset.
   `MTS_ASSERT_ALWAYS(a_reset, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
